// ===== rtl/core/obox_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package obox_pkg;

	// Fixed point layout
	localparam int FRAC_BITS = 16;
	localparam int UNIT_W    = 18;
	localparam int PUSH_W    = 32;
	localparam int THR_W     = 31;

	// Normalized magnitudes sit in [2^29, 2^30)
	localparam int NMAG_W = 30;

	// Normalizer lane depth
	localparam int SQRT_STEPS = 31;
	localparam int DIV_STEPS  = 17;
	localparam int NORM_LAT   = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;

	// Number of post-normalize stages in the top level, output register included
	localparam int TAIL_LAT = 6;

	typedef logic signed [UNIT_W-1:0] unit_t;

	typedef struct packed {
		logic [NMAG_W-1:0] mx;
		logic [NMAG_W-1:0] my;
		logic              neg_x;
		logic              neg_y;
		logic              zero;
	} norm_side_t;

endpackage

`default_nettype wire

// ===== rtl/core/obox_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface obox_in_if #(
	parameter int COORD_WIDTH = 32
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] dyn_center_x;
	logic signed [COORD_WIDTH-1:0] dyn_center_y;
	logic signed [COORD_WIDTH-1:0] dyn_half_u_x;
	logic signed [COORD_WIDTH-1:0] dyn_half_u_y;
	logic signed [COORD_WIDTH-1:0] dyn_half_v_x;
	logic signed [COORD_WIDTH-1:0] dyn_half_v_y;
	logic signed [COORD_WIDTH-1:0] fixed_center_x;
	logic signed [COORD_WIDTH-1:0] fixed_center_y;
	logic signed [COORD_WIDTH-1:0] fixed_half_u_x;
	logic signed [COORD_WIDTH-1:0] fixed_half_u_y;
	logic signed [COORD_WIDTH-1:0] fixed_half_v_x;
	logic signed [COORD_WIDTH-1:0] fixed_half_v_y;

	modport source (
		output valid, dyn_center_x, dyn_center_y, dyn_half_u_x, dyn_half_u_y,
		       dyn_half_v_x, dyn_half_v_y, fixed_center_x, fixed_center_y,
		       fixed_half_u_x, fixed_half_u_y, fixed_half_v_x, fixed_half_v_y,
		input  ready
	);

	modport sink (
		input  valid, dyn_center_x, dyn_center_y, dyn_half_u_x, dyn_half_u_y,
		       dyn_half_v_x, dyn_half_v_y, fixed_center_x, fixed_center_y,
		       fixed_half_u_x, fixed_half_u_y, fixed_half_v_x, fixed_half_v_y,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/obox_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface obox_out_if ();
	logic               valid;
	logic               ready;
	logic               hit;
	logic               true_overlap;
	logic signed [31:0] push_u_positive;
	logic signed [31:0] push_u_negative;
	logic signed [31:0] push_v_positive;
	logic signed [31:0] push_v_negative;
	logic signed [17:0] unit_u_x;
	logic signed [17:0] unit_u_y;
	logic signed [17:0] unit_v_x;
	logic signed [17:0] unit_v_y;

	modport source (
		output valid, hit, true_overlap, push_u_positive, push_u_negative,
		       push_v_positive, push_v_negative, unit_u_x, unit_u_y, unit_v_x, unit_v_y,
		input  ready
	);

	modport sink (
		input  valid, hit, true_overlap, push_u_positive, push_u_negative,
		       push_v_positive, push_v_negative, unit_u_x, unit_u_y, unit_v_x, unit_v_y,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/oriented_box_overlap_test.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Oriented box overlap test, 2D separating axes, fixed point Q16.16.
// boxes  : sink channel, one word = moving box + static box (centers and half-extent vectors).
// result : source channel, one word per accepted pair: hit, true_overlap, push depths on
//          the static u/v axes (saturated to 32 bits), static unit axes in Q1.16.
// cfg_we/cfg_wdata : write of collide_threshold (unsigned Q15.16, 31 bits), taken on any edge with
//          cfg_we high; only change it while the pipe is empty.
// Throughput: one pair per cycle, sustained while result.ready is high.
// The pipe starts with the normalizer lane: magnitudes, leading one, scale, squares, sum,
// 31 sqrt stages (one root digit each), numerators, 17 divide stages (one quotient bit each)
// and signs; then corners, products, projections, min/max, tests, output.
// Stall: the whole pipe moves on one enable; while result.valid is high and result.ready is
// low, every stage holds and boxes.ready is low. Bubbles travel with the pipe, not squeezed out.
// Reset: arst_n clears the valid bits and the threshold (0); payload is not reset.
// A zero-length axis normalizes to (0, 0): it never separates and clears true_overlap.
module oriented_box_overlap_test #(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	obox_in_if.sink                            boxes,
	obox_out_if.source                         result,
	input  wire logic                          cfg_we,
	input  wire logic [obox_pkg::THR_W-1:0]    cfg_wdata
);
	import obox_pkg::*;

	localparam int W    = COORD_WIDTH;
	localparam int CW   = W + 2;            // corner width, exact
	localparam int WP   = CW + UNIT_W;      // product width
	localparam int PW   = WP + 1 - FRAC_BITS; // projection width
	localparam int TW   = ((PW > PUSH_W) ? PW : PUSH_W) + 2; // test / push width
	localparam int NVLD = NORM_LAT + TAIL_LAT;

	localparam logic signed [TW-1:0] PUSH_MAX = TW'(64'sd2147483647);
	localparam logic signed [TW-1:0] PUSH_MIN = TW'(-64'sd2147483648);

	logic en;
	logic [THR_W-1:0] thr_q;
	logic vld_q [NVLD];

	logic signed [W-1:0] in_coord [12];
	logic signed [W-1:0] box_dly_s [NORM_LAT][12];
	unit_t lane_ux [4];
	unit_t lane_uy [4];

	// corners: 0..3 moving, 4..7 static; [k] 0 = x, 1 = y
	logic signed [CW-1:0] corner_c [8][2];
	logic signed [CW-1:0] corner_s1 [8][2];
	unit_t                axis_s1 [4][2];
	logic signed [WP-1:0] prod_s2 [4][8][2];
	unit_t                fax_s2 [2][2];
	logic signed [PW-1:0] proj_s3 [4][8];
	unit_t                fax_s3 [2][2];
	logic signed [PW-1:0] dmin_s4 [4];
	logic signed [PW-1:0] dmax_s4 [4];
	logic signed [PW-1:0] smin_s4 [4];
	logic signed [PW-1:0] smax_s4 [4];
	unit_t                fax_s4 [2][2];
	logic [3:0]           sep_s5;
	logic [3:0]           strict_s5;
	logic signed [PUSH_W-1:0] push_s5 [4];
	unit_t                fax_s5 [2][2];

	logic signed [PW-1:0] dmin_c [4];
	logic signed [PW-1:0] dmax_c [4];
	logic signed [PW-1:0] smin_c [4];
	logic signed [PW-1:0] smax_c [4];

	logic                     hit_s6, strict_s6;
	logic signed [PUSH_W-1:0] push_s6 [4];
	unit_t                    fax_s6 [2][2];

	function automatic logic signed [PUSH_W-1:0] sat32(input logic signed [TW-1:0] v);
		if (v > PUSH_MAX) return PUSH_W'(PUSH_MAX);
		if (v < PUSH_MIN) return PUSH_W'(PUSH_MIN);
		return PUSH_W'(v);
	endfunction

	assign en          = !vld_q[NVLD-1] || result.ready;
	assign boxes.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NVLD; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= boxes.valid;
			for (int i = 1; i < NVLD; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	assign in_coord[0]  = boxes.dyn_center_x;
	assign in_coord[1]  = boxes.dyn_center_y;
	assign in_coord[2]  = boxes.dyn_half_u_x;
	assign in_coord[3]  = boxes.dyn_half_u_y;
	assign in_coord[4]  = boxes.dyn_half_v_x;
	assign in_coord[5]  = boxes.dyn_half_v_y;
	assign in_coord[6]  = boxes.fixed_center_x;
	assign in_coord[7]  = boxes.fixed_center_y;
	assign in_coord[8]  = boxes.fixed_half_u_x;
	assign in_coord[9]  = boxes.fixed_half_u_y;
	assign in_coord[10] = boxes.fixed_half_v_x;
	assign in_coord[11] = boxes.fixed_half_v_y;

	// raw boxes wait alongside the normalizers
	always_ff @(posedge clk) begin
		if (en) begin
			box_dly_s[0] <= in_coord;
			for (int i = 1; i < NORM_LAT; i++) box_dly_s[i] <= box_dly_s[i-1];
		end
	end

	// axes in test order: moving u, moving v, static u, static v
	for (genvar a = 0; a < 4; a++) begin : g_lane
		obox_norm #(
			.COORD_WIDTH(COORD_WIDTH)
		) u_norm (
			.clk(clk),
			.en (en),
			.x  (in_coord[2 + 2*(a%2) + 6*(a/2)]),
			.y  (in_coord[3 + 2*(a%2) + 6*(a/2)]),
			.ux (lane_ux[a]),
			.uy (lane_uy[a])
		);
	end

	// corners: center +/- u +/- v, exact
	always_comb begin
		for (int b = 0; b < 2; b++) begin
			for (int j = 0; j < 4; j++) begin
				for (int k = 0; k < 2; k++) begin
					corner_c[b*4+j][k] = CW'(box_dly_s[NORM_LAT-1][b*6+k])
						+ (((j & 2) != 0) ? -CW'(box_dly_s[NORM_LAT-1][b*6+2+k])
						                  :  CW'(box_dly_s[NORM_LAT-1][b*6+2+k]))
						+ (((j & 1) != 0) ? -CW'(box_dly_s[NORM_LAT-1][b*6+4+k])
						                  :  CW'(box_dly_s[NORM_LAT-1][b*6+4+k]));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			corner_s1 <= corner_c;
			for (int a = 0; a < 4; a++) begin
				axis_s1[a][0] <= lane_ux[a];
				axis_s1[a][1] <= lane_uy[a];
			end
		end
	end

	// full products; each term is floored on its own in the next stage
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 4; a++) begin
				for (int c = 0; c < 8; c++) begin
					for (int k = 0; k < 2; k++) begin
						prod_s2[a][c][k] <= WP'(axis_s1[a][k]) * WP'(corner_s1[c][k]);
					end
				end
			end
			fax_s2[0] <= axis_s1[2];
			fax_s2[1] <= axis_s1[3];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 4; a++) begin
				for (int c = 0; c < 8; c++) begin
					proj_s3[a][c] <= PW'((prod_s2[a][c][0] >>> FRAC_BITS)
						+ (prod_s2[a][c][1] >>> FRAC_BITS));
				end
			end
			fax_s3 <= fax_s2;
		end
	end

	// min/max start from the first corner of each box
	always_comb begin
		for (int a = 0; a < 4; a++) begin
			dmin_c[a] = proj_s3[a][0];
			dmax_c[a] = proj_s3[a][0];
			smin_c[a] = proj_s3[a][4];
			smax_c[a] = proj_s3[a][4];
			for (int j = 1; j < 4; j++) begin
				if (proj_s3[a][j] < dmin_c[a]) dmin_c[a] = proj_s3[a][j];
				if (proj_s3[a][j] > dmax_c[a]) dmax_c[a] = proj_s3[a][j];
				if (proj_s3[a][4+j] < smin_c[a]) smin_c[a] = proj_s3[a][4+j];
				if (proj_s3[a][4+j] > smax_c[a]) smax_c[a] = proj_s3[a][4+j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dmin_s4 <= dmin_c;
			dmax_s4 <= dmax_c;
			smin_s4 <= smin_c;
			smax_s4 <= smax_c;
			fax_s4  <= fax_s3;
		end
	end

	// per axis separation with threshold, strict overlap, static-axis pushes
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 4; a++) begin
				sep_s5[a] <= ((TW'(smin_s4[a]) - TW'($signed({1'b0, thr_q}))) > TW'(dmax_s4[a]))
				          || ((TW'(smax_s4[a]) + TW'($signed({1'b0, thr_q}))) < TW'(dmin_s4[a]));
				strict_s5[a] <= (smin_s4[a] < dmax_s4[a]) && (smax_s4[a] > dmin_s4[a]);
			end
			for (int i = 0; i < 2; i++) begin
				push_s5[2*i]   <= sat32(TW'(smax_s4[2+i]) - TW'(dmin_s4[2+i]));
				push_s5[2*i+1] <= sat32(TW'(smin_s4[2+i]) - TW'(dmax_s4[2+i]));
			end
			fax_s5 <= fax_s4;
		end
	end

	// output register; no hit zeroes overlap and pushes
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s6    <= ~|sep_s5;
			strict_s6 <= (~|sep_s5) && (&strict_s5);
			for (int i = 0; i < 4; i++) begin
				push_s6[i] <= (~|sep_s5) ? push_s5[i] : '0;
			end
			fax_s6 <= fax_s5;
		end
	end

	assign result.valid           = vld_q[NVLD-1];
	assign result.hit             = hit_s6;
	assign result.true_overlap    = strict_s6;
	assign result.push_u_positive = push_s6[0];
	assign result.push_u_negative = push_s6[1];
	assign result.push_v_positive = push_s6[2];
	assign result.push_v_negative = push_s6[3];
	assign result.unit_u_x        = fax_s6[0][0];
	assign result.unit_u_y        = fax_s6[0][1];
	assign result.unit_v_x        = fax_s6[1][0];
	assign result.unit_v_y        = fax_s6[1][1];

`ifndef SYNTHESIS
	a_nohit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.hit |-> !result.true_overlap
			&& result.push_u_positive == 0 && result.push_u_negative == 0
			&& result.push_v_positive == 0 && result.push_v_negative == 0)
		else $error("no-hit word carries overlap or push data");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.unit_u_x <= 18'sd65536 && result.unit_u_x >= -18'sd65536
			&& result.unit_v_y <= 18'sd65536 && result.unit_v_y >= -18'sd65536)
		else $error("unit axis component out of range");

	a_zero_axis: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && ((result.unit_u_x == 0 && result.unit_u_y == 0)
			|| (result.unit_v_x == 0 && result.unit_v_y == 0)) |-> !result.true_overlap)
		else $error("zero static axis reported as true overlap");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/obox_norm.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pipelined 2D vector normalizer: scale, square, sqrt (one digit/stage),
// divide (one quotient bit/stage), restore signs.
module obox_norm #(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [COORD_WIDTH-1:0] x,
	input  wire logic signed [COORD_WIDTH-1:0] y,
	output obox_pkg::unit_t                    ux,
	output obox_pkg::unit_t                    uy
);
	import obox_pkg::*;

	localparam int W    = COORD_WIDTH;
	localparam int POSW = $clog2(COORD_WIDTH);
	localparam int SQW  = 2 * SQRT_STEPS;
	localparam int RTW  = SQRT_STEPS;
	localparam int REMW = RTW + 2;
	localparam int NUMW = NMAG_W + FRAC_BITS + 1;
	localparam int DREMW = RTW;

	// stage 1: magnitudes
	logic [W-1:0] mx_s1, my_s1, m_s1;
	logic         neg_x_s1, neg_y_s1;
	// stage 2: leading one
	logic [W-1:0]    mx_s2, my_s2;
	logic [POSW-1:0] pos_s2;
	logic            neg_x_s2, neg_y_s2, zero_s2;
	// stage 3: scaled magnitudes
	norm_side_t side_s3;
	// stage 4: squares
	norm_side_t side_s4;
	logic [2*NMAG_W-1:0] sqx_s4, sqy_s4;

	// sqrt chain, index 0 is the sum stage
	logic [SQW-1:0]  sq_val_s  [SQRT_STEPS+1];
	logic [RTW-1:0]  sq_root_s [SQRT_STEPS+1];
	logic [REMW-1:0] sq_rem_s  [SQRT_STEPS+1];
	norm_side_t      sq_side_s [SQRT_STEPS+1];

	// divide chain, index 0 is the numerator stage
	logic [DREMW-1:0]     dv_rx_s   [DIV_STEPS+1];
	logic [DREMW-1:0]     dv_ry_s   [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] dv_nx_s   [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] dv_ny_s   [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] dv_qx_s   [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] dv_qy_s   [DIV_STEPS+1];
	logic [RTW-1:0]       dv_r_s    [DIV_STEPS+1];
	logic                 dv_negx_s [DIV_STEPS+1];
	logic                 dv_negy_s [DIV_STEPS+1];
	logic                 dv_zero_s [DIV_STEPS+1];

	logic [W-1:0]    mag_x, mag_y;
	logic [POSW-1:0] pos_c;
	logic [W+NMAG_W-1:0] ext_x, ext_y;
	logic [POSW:0]   shamt;
	logic [NUMW-1:0] num_x, num_y;
	logic [UNIT_W-1:0] qx_ext, qy_ext;

	assign mag_x = x[W-1] ? (W'(0) - $unsigned(x)) : $unsigned(x);
	assign mag_y = y[W-1] ? (W'(0) - $unsigned(y)) : $unsigned(y);

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1    <= mag_x;
			my_s1    <= mag_y;
			m_s1     <= (mag_x > mag_y) ? mag_x : mag_y;
			neg_x_s1 <= x[W-1];
			neg_y_s1 <= y[W-1];
		end
	end

	always_comb begin
		pos_c = '0;
		for (int i = 0; i < W; i++) begin
			if (m_s1[i]) pos_c = POSW'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2    <= mx_s1;
			my_s2    <= my_s1;
			pos_s2   <= pos_c;
			neg_x_s2 <= neg_x_s1;
			neg_y_s2 <= neg_y_s1;
			zero_s2  <= (m_s1 == '0);
		end
	end

	// shift so the larger magnitude lands in [2^29, 2^30); right shifts truncate
	assign shamt = (POSW+1)'(pos_s2) + (POSW+1)'(1);
	assign ext_x = {mx_s2, NMAG_W'(0)} >> shamt;
	assign ext_y = {my_s2, NMAG_W'(0)} >> shamt;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.mx    <= ext_x[NMAG_W-1:0];
			side_s3.my    <= ext_y[NMAG_W-1:0];
			side_s3.neg_x <= neg_x_s2;
			side_s3.neg_y <= neg_y_s2;
			side_s3.zero  <= zero_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			sqx_s4  <= (2*NMAG_W)'(side_s3.mx) * (2*NMAG_W)'(side_s3.mx);
			sqy_s4  <= (2*NMAG_W)'(side_s3.my) * (2*NMAG_W)'(side_s3.my);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_val_s[0]  <= SQW'(sqx_s4) + SQW'(sqy_s4);
			sq_root_s[0] <= '0;
			sq_rem_s[0]  <= '0;
			sq_side_s[0] <= side_s4;
		end
	end

	// one root digit per stage
	for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
		logic [REMW+1:0] t, trial;
		assign t     = {sq_rem_s[k-1], sq_val_s[k-1][SQW-1 -: 2]};
		assign trial = (REMW+2)'({sq_root_s[k-1], 2'b01});
		always_ff @(posedge clk) begin
			if (en) begin
				sq_val_s[k]  <= {sq_val_s[k-1][SQW-3:0], 2'b00};
				sq_side_s[k] <= sq_side_s[k-1];
				if (t >= trial) begin
					sq_rem_s[k]  <= REMW'(t - trial);
					sq_root_s[k] <= {sq_root_s[k-1][RTW-2:0], 1'b1};
				end else begin
					sq_rem_s[k]  <= REMW'(t);
					sq_root_s[k] <= {sq_root_s[k-1][RTW-2:0], 1'b0};
				end
			end
		end
	end

	// numerators m * 2^16 + r/2
	assign num_x = NUMW'({sq_side_s[SQRT_STEPS].mx, FRAC_BITS'(0)})
		+ NUMW'(sq_root_s[SQRT_STEPS] >> 1);
	assign num_y = NUMW'({sq_side_s[SQRT_STEPS].my, FRAC_BITS'(0)})
		+ NUMW'(sq_root_s[SQRT_STEPS] >> 1);

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rx_s[0]   <= DREMW'(num_x[NUMW-1:DIV_STEPS]);
			dv_ry_s[0]   <= DREMW'(num_y[NUMW-1:DIV_STEPS]);
			dv_nx_s[0]   <= num_x[DIV_STEPS-1:0];
			dv_ny_s[0]   <= num_y[DIV_STEPS-1:0];
			dv_qx_s[0]   <= '0;
			dv_qy_s[0]   <= '0;
			dv_r_s[0]    <= sq_root_s[SQRT_STEPS];
			dv_negx_s[0] <= sq_side_s[SQRT_STEPS].neg_x;
			dv_negy_s[0] <= sq_side_s[SQRT_STEPS].neg_y;
			dv_zero_s[0] <= sq_side_s[SQRT_STEPS].zero;
		end
	end

	// one quotient bit per stage, partial remainder stays below r
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
		logic [DREMW:0] tx, ty, dd;
		assign tx = {dv_rx_s[k-1], dv_nx_s[k-1][DIV_STEPS-1]};
		assign ty = {dv_ry_s[k-1], dv_ny_s[k-1][DIV_STEPS-1]};
		assign dd = {1'b0, dv_r_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				dv_nx_s[k]   <= {dv_nx_s[k-1][DIV_STEPS-2:0], 1'b0};
				dv_ny_s[k]   <= {dv_ny_s[k-1][DIV_STEPS-2:0], 1'b0};
				dv_r_s[k]    <= dv_r_s[k-1];
				dv_negx_s[k] <= dv_negx_s[k-1];
				dv_negy_s[k] <= dv_negy_s[k-1];
				dv_zero_s[k] <= dv_zero_s[k-1];
				if (tx >= dd) begin
					dv_rx_s[k] <= DREMW'(tx - dd);
					dv_qx_s[k] <= {dv_qx_s[k-1][DIV_STEPS-2:0], 1'b1};
				end else begin
					dv_rx_s[k] <= DREMW'(tx);
					dv_qx_s[k] <= {dv_qx_s[k-1][DIV_STEPS-2:0], 1'b0};
				end
				if (ty >= dd) begin
					dv_ry_s[k] <= DREMW'(ty - dd);
					dv_qy_s[k] <= {dv_qy_s[k-1][DIV_STEPS-2:0], 1'b1};
				end else begin
					dv_ry_s[k] <= DREMW'(ty);
					dv_qy_s[k] <= {dv_qy_s[k-1][DIV_STEPS-2:0], 1'b0};
				end
			end
		end
	end

	assign qx_ext = UNIT_W'(dv_qx_s[DIV_STEPS]);
	assign qy_ext = UNIT_W'(dv_qy_s[DIV_STEPS]);

	always_ff @(posedge clk) begin
		if (en) begin
			if (dv_zero_s[DIV_STEPS]) begin
				ux <= '0;
				uy <= '0;
			end else begin
				ux <= dv_negx_s[DIV_STEPS] ? unit_t'(UNIT_W'(0) - qx_ext) : unit_t'(qx_ext);
				uy <= dv_negy_s[DIV_STEPS] ? unit_t'(UNIT_W'(0) - qy_ext) : unit_t'(qy_ext);
			end
		end
	end

endmodule

`default_nettype wire

// ===== dv/obox_tb_if.sv =====
`timescale 1ns / 1ps

// Testbench-side view of the two channels is the RTL interfaces themselves;
// this file holds the expected-result word used by the checker.
package obox_tb_pkg;

	typedef struct packed {
		logic               hit;
		logic               true_overlap;
		logic signed [31:0] push_u_positive;
		logic signed [31:0] push_u_negative;
		logic signed [31:0] push_v_positive;
		logic signed [31:0] push_v_negative;
		logic signed [17:0] unit_u_x;
		logic signed [17:0] unit_u_y;
		logic signed [17:0] unit_v_x;
		logic signed [17:0] unit_v_y;
	} overlap_word_t;

endpackage

// ===== dv/tb_oriented_box_overlap_test.sv =====
`timescale 1ns / 1ps

module tb_oriented_box_overlap_test;
	import obox_pkg::*;
	import obox_tb_pkg::*;

	// pipe depth from the accepting edge; the drain wait adds margin on top of it
	localparam int PIPE_LAT    = NORM_LAT + TAIL_LAT;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [THR_W-1:0] cfg_wdata;

	obox_in_if  #(.COORD_WIDTH(32)) boxes ();
	obox_out_if                     result ();

	oriented_box_overlap_test #(.COORD_WIDTH(32)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.boxes     (boxes),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// threshold as the predictor sees it
	logic [THR_W-1:0] margin;
	overlap_word_t    pending_words[$];
	int               mismatches;
	int               hits_seen;
	int               strict_seen;
	int               words_sent;
	int               stall_mode;  // 0: no receiver stalls, 1: random stalls
	longint           cycle_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung pipe ends the run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	//----------------------------------------------------------------------
	// Predictor
	//----------------------------------------------------------------------

	function automatic longint unsigned root64(longint unsigned s);
		longint unsigned res, bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv >>= 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s   = s - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// unit vector of (x, y) in Q1.16; a zero vector stays zero
	function automatic void unit_axis(input longint x, input longint y,
			output longint ux, output longint uy);
		longint unsigned mx, my, m, r, qx, qy;
		mx = (x < 0) ? -x : x;
		my = (y < 0) ? -y : y;
		m  = (mx > my) ? mx : my;
		if (m == 0) begin
			ux = 0;
			uy = 0;
			return;
		end
		while (m >= (64'd1 << 30)) begin
			mx >>= 1; my >>= 1; m >>= 1;
		end
		while (m < (64'd1 << 29)) begin
			mx <<= 1; my <<= 1; m <<= 1;
		end
		r  = root64(mx * mx + my * my);
		qx = (mx * 65536 + r / 2) / r;
		qy = (my * 65536 + r / 2) / r;
		ux = (x < 0) ? -longint'(qx) : longint'(qx);
		uy = (y < 0) ? -longint'(qy) : longint'(qy);
	endfunction

	// floor(a*p / 2^16), split so nothing leaves 64 bits
	function automatic longint scaled_term(longint a, longint p);
		longint lo, hi, n;
		lo = p & 64'hFFFF;
		hi = (p - lo) >>> 16;
		n  = a * lo;
		return a * hi + (n >>> 16);
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// f: dyn cx, cy, ux, uy, vx, vy, then the same for the static box
	function automatic overlap_word_t predict_overlap(logic signed [31:0] f[12]);
		overlap_word_t w;
		longint g[12];
		longint ax[4], ay[4];
		longint cx[8], cy[8];
		longint pushes[4];
		longint dmin, dmax, smin, smax, p, thr, sx, sy;
		bit is_hit, strict;
		for (int i = 0; i < 12; i++) g[i] = f[i];
		for (int b = 0; b < 2; b++) begin
			for (int j = 0; j < 4; j++) begin
				sx = (j & 2) ? -1 : 1;
				sy = (j & 1) ? -1 : 1;
				cx[b*4+j] = g[b*6] + sx * g[b*6+2] + sy * g[b*6+4];
				cy[b*4+j] = g[b*6+1] + sx * g[b*6+3] + sy * g[b*6+5];
			end
			unit_axis(g[b*6+2], g[b*6+3], ax[b*2], ay[b*2]);
			unit_axis(g[b*6+4], g[b*6+5], ax[b*2+1], ay[b*2+1]);
		end
		pushes = '{0, 0, 0, 0};
		thr    = margin;
		is_hit = 1'b1;
		strict = 1'b1;
		// dyn u, dyn v, static u, static v; first separating axis ends the test
		for (int i = 0; i < 4 && is_hit; i++) begin
			for (int j = 0; j < 4; j++) begin
				p = scaled_term(ax[i], cx[j]) + scaled_term(ay[i], cy[j]);
				if (j == 0 || p < dmin) dmin = p;
				if (j == 0 || p > dmax) dmax = p;
				p = scaled_term(ax[i], cx[4+j]) + scaled_term(ay[i], cy[4+j]);
				if (j == 0 || p < smin) smin = p;
				if (j == 0 || p > smax) smax = p;
			end
			if (smin - thr > dmax || smax + thr < dmin) begin
				is_hit = 1'b0;
			end else begin
				if (!(smin < dmax && smax > dmin)) strict = 1'b0;
				if (i >= 2) begin
					pushes[(i-2)*2]   = smax - dmin;
					pushes[(i-2)*2+1] = smin - dmax;
				end
			end
		end
		w.hit             = is_hit;
		w.true_overlap    = is_hit && strict;
		w.push_u_positive = is_hit ? clamp32(pushes[0]) : '0;
		w.push_u_negative = is_hit ? clamp32(pushes[1]) : '0;
		w.push_v_positive = is_hit ? clamp32(pushes[2]) : '0;
		w.push_v_negative = is_hit ? clamp32(pushes[3]) : '0;
		w.unit_u_x        = ax[2][17:0];
		w.unit_u_y        = ay[2][17:0];
		w.unit_v_x        = ax[3][17:0];
		w.unit_v_y        = ay[3][17:0];
		return w;
	endfunction

	//----------------------------------------------------------------------
	// Driver side
	//----------------------------------------------------------------------

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	int gap_mode;  // 0: back to back, 1: random gaps

	// Presents one word, holds it until taken, queues its prediction.
	task automatic send_boxes(logic signed [31:0] f[12]);
		int gap;
		gap = (gap_mode != 0) ? gap_len() : 0;
		if (gap > 0) begin
			boxes.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		boxes.valid          <= 1'b1;
		boxes.dyn_center_x   <= f[0];
		boxes.dyn_center_y   <= f[1];
		boxes.dyn_half_u_x   <= f[2];
		boxes.dyn_half_u_y   <= f[3];
		boxes.dyn_half_v_x   <= f[4];
		boxes.dyn_half_v_y   <= f[5];
		boxes.fixed_center_x <= f[6];
		boxes.fixed_center_y <= f[7];
		boxes.fixed_half_u_x <= f[8];
		boxes.fixed_half_u_y <= f[9];
		boxes.fixed_half_v_x <= f[10];
		boxes.fixed_half_v_y <= f[11];
		// word enters the queue before the result can possibly appear
		pending_words.push_back(predict_overlap(f));
		words_sent++;
		do @(posedge clk); while (!boxes.ready);
	endtask

	// drop valid once the stream pauses
	task automatic idle_input();
		boxes.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every word is back; extra cycles cover the pipe depth.
	task automatic drain_pipe();
		idle_input();
		while (pending_words.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	task automatic write_margin(logic [THR_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		margin     = value;
		@(posedge clk);
	endtask

	//----------------------------------------------------------------------
	// Receiver side and checker
	//----------------------------------------------------------------------

	always @(posedge clk) begin
		if (stall_mode == 0) result.ready <= 1'b1;
		else result.ready <= (gap_len() == 0) || ($urandom_range(0, 1) == 1);
	end

	always @(posedge clk) begin
		overlap_word_t want, got;
		if (arst_n && result.valid && result.ready) begin
			got.hit             = result.hit;
			got.true_overlap    = result.true_overlap;
			got.push_u_positive = result.push_u_positive;
			got.push_u_negative = result.push_u_negative;
			got.push_v_positive = result.push_v_positive;
			got.push_v_negative = result.push_v_negative;
			got.unit_u_x        = result.unit_u_x;
			got.unit_u_y        = result.unit_u_y;
			got.unit_v_x        = result.unit_v_x;
			got.unit_v_y        = result.unit_v_y;
			if (pending_words.size() == 0) begin
				$display("%0t: result word with nothing expected, actual %p", $time, got);
				mismatches++;
			end else begin
				want = pending_words.pop_front();
				if (got !== want) begin
					mismatches++;
					$display("%0t: mismatch expected %p actual %p", $time, want, got);
				end
				if (got.hit) hits_seen++;
				if (got.true_overlap) strict_seen++;
			end
		end
	end

	//----------------------------------------------------------------------
	// Stimulus helpers
	//----------------------------------------------------------------------

	function automatic logic signed [31:0] any_coord();
		return $urandom();
	endfunction

	// coordinate in +-range with a random fraction
	function automatic logic signed [31:0] near_coord(int whole);
		logic signed [31:0] v;
		v = $urandom_range(0, whole << 16);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	// Two boxes placed close enough that all four axes are usually exercised.
	task automatic near_pair(output logic signed [31:0] f[12], input int reach);
		for (int i = 0; i < 12; i++) f[i] = near_coord(reach);
		f[6] = f[0] + near_coord(2 * reach);
		f[7] = f[1] + near_coord(2 * reach);
	endtask

	//----------------------------------------------------------------------
	// Tests
	//----------------------------------------------------------------------

	task automatic test_directed();
		logic signed [31:0] f[12];
		// identical axis-aligned squares (half extent 1.0) at the origin: strict overlap
		f = '{0, 0, 32'sh10000, 0, 0, 32'sh10000, 0, 0, 32'sh10000, 0, 0, 32'sh10000};
		send_boxes(f);
		// far apart on x: separated on the first axis
		f[6] = 32'sh0100_0000;
		send_boxes(f);
		// touching edges: hit but not strict
		f[6] = 32'sh20000;
		send_boxes(f);
		// zero-length static axis and zero moving axis
		f = '{0, 0, 0, 0, 32'sh10000, 0, 32'sh8000, 0, 0, 0, 0, 32'sh30000};
		send_boxes(f);
		// every field zero
		f = '{default: 0};
		send_boxes(f);
		// all fields at the positive extreme, then the negative one
		f = '{default: 32'sh7FFF_FFFF};
		send_boxes(f);
		f = '{default: 32'sh8000_0000};
		send_boxes(f);
		// all ones (-1 lsb) and mixed extremes that make corners overflow 32 bits
		f = '{default: -32'sd1};
		send_boxes(f);
		f = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
		send_boxes(f);
		// huge overlapping boxes: push depths saturate
		f = '{0, 0, 32'sh4000_0000, 0, 0, 32'sh4000_0000,
			0, 0, 32'sh4000_0000, 0, 0, 32'sh4000_0000};
		send_boxes(f);
		// rotated 45 degrees and tiny axes (1 lsb) that need the left shift
		f = '{0, 0, 32'sh10000, 32'sh10000, -32'sh10000, 32'sh10000,
			32'sh8000, 0, 1, 1, -1, 1};
		send_boxes(f);
		f = '{32'sh50000, 0, 1, 0, 0, 1, 0, 0, 0, -1, 3, 0};
		send_boxes(f);
		drain_pipe();
	endtask

	// random pairs under one threshold; count words
	task automatic test_random(int count);
		logic signed [31:0] f[12];
		int pick;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 9))
				0: for (int i = 0; i < 12; i++) f[i] = any_coord();
				1: near_pair(f, 30000);
				2: begin
					// one static axis degenerate
					near_pair(f, 8);
					pick = 2 * $urandom_range(0, 1);
					f[8 + pick] = 0;
					f[9 + pick] = 0;
				end
				default: near_pair(f, $urandom_range(0, 1) ? 4 : 200);
			endcase
			send_boxes(f);
		end
	endtask

	task automatic test_thresholds();
		// reset value first, then a spread including both ends of the register
		logic [THR_W-1:0] settings[5];
		settings = '{0, 31'h1_0000, 31'h8_0000, 31'h0000_7FFF, 31'h7FFF_FFFF};
		foreach (settings[k]) begin
			write_margin(settings[k]);
			gap_mode   = k % 2;
			stall_mode = (k == 0) ? 0 : 1;
			test_random(190);
			drain_pipe();
		end
	endtask

	// back to back with no receiver stall, then random gaps with random receiver stalls
	task automatic test_throughput();
		gap_mode   = 0;
		stall_mode = 0;
		test_random(50);
		stall_mode = 1;
		gap_mode   = 1;
		test_random(50);
		// hold the sender until every word is back, then resume
		idle_input();
		while (pending_words.size() != 0) @(posedge clk);
		test_random(20);
		drain_pipe();
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		margin       = '0;
		mismatches   = 0;
		hits_seen    = 0;
		strict_seen  = 0;
		words_sent   = 0;
		gap_mode     = 0;
		stall_mode   = 0;
		cycle_cnt    = 0;
		result.ready = 1'b0;
		boxes.valid  = 1'b0;
		{boxes.dyn_center_x, boxes.dyn_center_y, boxes.dyn_half_u_x, boxes.dyn_half_u_y,
			boxes.dyn_half_v_x, boxes.dyn_half_v_y, boxes.fixed_center_x,
			boxes.fixed_center_y, boxes.fixed_half_u_x, boxes.fixed_half_u_y,
			boxes.fixed_half_v_x, boxes.fixed_half_v_y} = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_thresholds();
		test_throughput();

		$display("Sent %0d box pairs over five threshold settings, gaps and stalls;",
			words_sent);
		$display("%0d hits, %0d strict overlaps, %0d mismatches.",
			hits_seen, strict_seen, mismatches);
		if (mismatches == 0 && pending_words.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
